[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by the checker file fr_checker
// ----------------------------------------------------------------------------
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define FR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define FR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fr_pkg.sv]
// ----------------------------------------------------------------------------
// fr_pkg
// shared types and constants of the fraction reduction block
// ----------------------------------------------------------------------------
package fr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  localparam logic [DATA_WIDTH-1:0] DATA_ONE  = DATA_WIDTH'(1);
  localparam logic [DATA_WIDTH-1:0] DATA_ZERO = '0;
  localparam logic [CNT_W-1:0]      CNT_LAST  = CNT_W'(DATA_WIDTH - 1);
  localparam logic [CNT_W-1:0]      CNT_ZERO  = '0;
  localparam logic [CNT_W-1:0]      CNT_ONE   = CNT_W'(1);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator_in;
    logic signed [DATA_WIDTH-1:0] denominator_in;
  } fr_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator_out;
    logic signed [DATA_WIDTH-1:0] denominator_out;
  } fr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } fr_state_t;

endpackage

[hw/rtl/fraction_reduce.sv]
// result valid in the cycle after accept for a word left unreduced (zero or negative after
//   normalization), else after the gcd, one rescale step per common factor of two, then
//   the numerator and denominator divisions; gcd does one shift, swap or subtract per cycle
// throughput: one word at a time, input reopens the cycle after the result is taken
// reset: synchronous active-low rst_n returns the sequencer to idle, no word held
// ----------------------------------------------------------------------------
// fraction_reduce
// normalizes a signed fraction and, when both parts are positive, divides them by their gcd
// ----------------------------------------------------------------------------
module fraction_reduce (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fr_pkg::fr_in_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fr_pkg::fr_out_t   out_data
);

  localparam int W = fr_pkg::DATA_WIDTH;

  // sequencer
  fr_pkg::fr_state_t state_r, state_nxt;

  // gcd operands, a_r also holds the divisor during the divisions
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;
  // count of common factors of two stripped by the gcd
  logic [fr_pkg::CNT_W-1:0] k_r, k_nxt;
  // fraction being worked on, receives the quotients
  logic [W-1:0] num_r, num_nxt;
  logic [W-1:0] den_r, den_nxt;
  // restoring divider: dividend shifts out of quot_r while quotient shifts in
  logic [W-1:0] quot_r, quot_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [fr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic div_sel_r, div_sel_nxt;   // 0: numerator pass, 1: denominator pass

  // input normalization
  logic [W-1:0] in_num, in_den_nz, norm_num, norm_den;
  logic both_neg, both_pos;

  // shared subtract unit
  logic [W-1:0] op_a, op_b;
  logic [W:0]   diff;
  logic         borrow;
  logic [W-1:0] rem_shift;

  logic gcd_equal;
  logic div_start;
  logic div_last;

  // zero denominator becomes one, double negative flips both (wrapping)
  always_comb begin
    in_num    = in_data.numerator_in;
    in_den_nz = (in_data.denominator_in == fr_pkg::DATA_ZERO) ? fr_pkg::DATA_ONE
                                                              : in_data.denominator_in;
    both_neg  = in_num[W-1] & in_den_nz[W-1];
    norm_num  = both_neg ? (fr_pkg::DATA_ZERO - in_num)    : in_num;
    norm_den  = both_neg ? (fr_pkg::DATA_ZERO - in_den_nz) : in_den_nz;
    // most negative pair stays negative and passes through
    both_pos  = (norm_num != fr_pkg::DATA_ZERO) & ~norm_num[W-1] & ~norm_den[W-1];
  end

  // operand select for the one subtractor
  always_comb begin
    rem_shift = {rem_r[W-2:0], quot_r[W-1]};
    op_a      = a_r;
    op_b      = b_r;
    if (state_r == fr_pkg::ST_DIV) begin
      op_a = rem_shift;
      op_b = a_r;
    end
    diff   = {1'b0, op_a} - {1'b0, op_b};
    borrow = diff[W];
  end

  assign gcd_equal = (a_r == b_r);
  assign div_last  = (cnt_r == fr_pkg::CNT_ZERO);

  // divider starts once the gcd sits fully rescaled in a_r
  assign div_start = ((state_r == fr_pkg::ST_GCD) && gcd_equal && (k_r == fr_pkg::CNT_ZERO)) ||
                     ((state_r == fr_pkg::ST_SCALE) && (k_r == fr_pkg::CNT_ONE));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = both_pos ? fr_pkg::ST_GCD : fr_pkg::ST_DONE;
        end
      end
      fr_pkg::ST_GCD: begin
        if (gcd_equal) begin
          state_nxt = (k_r == fr_pkg::CNT_ZERO) ? fr_pkg::ST_DIV : fr_pkg::ST_SCALE;
        end
      end
      fr_pkg::ST_SCALE: begin
        if (k_r == fr_pkg::CNT_ONE) begin
          state_nxt = fr_pkg::ST_DIV;
        end
      end
      fr_pkg::ST_DIV: begin
        if (div_last && div_sel_r) begin
          state_nxt = fr_pkg::ST_DONE;
        end
      end
      fr_pkg::ST_DONE: begin
        if (!out_stall) begin
          state_nxt = fr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fr_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    a_nxt       = a_r;
    b_nxt       = b_r;
    k_nxt       = k_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    quot_nxt    = quot_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    div_sel_nxt = div_sel_r;
    case (state_r)
      fr_pkg::ST_IDLE: begin
        if (in_valid) begin
          num_nxt = norm_num;
          den_nxt = norm_den;
          a_nxt   = norm_num;
          b_nxt   = norm_den;
          k_nxt   = fr_pkg::CNT_ZERO;
        end
      end
      fr_pkg::ST_GCD: begin
        // binary gcd, one shift, swap or subtract per cycle
        if (!gcd_equal) begin
          if (!a_r[0] && !b_r[0]) begin
            a_nxt = a_r >> 1;
            b_nxt = b_r >> 1;
            k_nxt = k_r + fr_pkg::CNT_ONE;
          end else if (!a_r[0]) begin
            a_nxt = a_r >> 1;
          end else if (!b_r[0]) begin
            b_nxt = b_r >> 1;
          end else if (borrow) begin
            // keep the larger value in a
            a_nxt = b_r;
            b_nxt = a_r;
          end else begin
            a_nxt = diff[W-1:0];
          end
        end
      end
      fr_pkg::ST_SCALE: begin
        a_nxt = a_r << 1;
        k_nxt = k_r - fr_pkg::CNT_ONE;
      end
      fr_pkg::ST_DIV: begin
        // restoring step, remainder stays below the divisor
        if (borrow) begin
          rem_nxt  = rem_shift;
          quot_nxt = {quot_r[W-2:0], 1'b0};
        end else begin
          rem_nxt  = diff[W-1:0];
          quot_nxt = {quot_r[W-2:0], 1'b1};
        end
        cnt_nxt = cnt_r - fr_pkg::CNT_ONE;
        if (div_last) begin
          if (!div_sel_r) begin
            num_nxt     = quot_nxt;
            quot_nxt    = den_r;
            rem_nxt     = fr_pkg::DATA_ZERO;
            cnt_nxt     = fr_pkg::CNT_LAST;
            div_sel_nxt = 1'b1;
          end else begin
            den_nxt = quot_nxt;
          end
        end
      end
      default: begin
      end
    endcase
    if (div_start) begin
      quot_nxt    = num_r;
      rem_nxt     = fr_pkg::DATA_ZERO;
      cnt_nxt     = fr_pkg::CNT_LAST;
      div_sel_nxt = 1'b0;
    end
    if (state_r == fr_pkg::ST_SCALE) begin
      a_nxt = a_r << 1;
    end
  end

  // handshake outputs
  always_comb begin
    in_stall                 = (state_r != fr_pkg::ST_IDLE);
    out_valid                = (state_r == fr_pkg::ST_DONE);
    out_data.numerator_out   = num_r;
    out_data.denominator_out = den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    k_r       <= k_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    div_sel_r <= div_sel_nxt;
  end

endmodule

[hw/rtl/fr_checker.sv]
// ----------------------------------------------------------------------------
// fr_checker
// port-level checks of the fraction reduction block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fr_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input fr_pkg::fr_out_t out_data
);

  logic in_acc;

  assign in_acc = in_valid & ~in_stall;

  // a held word stays
  `FR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out word dropped")
  `FR_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "out word changed")
  // one word in flight at a time
  `FR_ASSERT_NOW(a_one_word, out_valid, in_stall, "input open while result pending")
  `FR_ASSERT_NEXT(a_busy_after_acc, in_acc, in_stall, "input open right after accept")
  // denominator never zero
  `FR_ASSERT_NOW(a_den_nonzero, out_valid, out_data.denominator_out != '0, "zero denominator")

endmodule

bind fraction_reduce fr_checker u_fr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
